[hw/rtl/hcbd_pkg.sv]
// Shared constants for the HTTP chunked body decoder.
package hcbd_pkg;

  localparam int unsigned MAX_SIZE_DIGITS_DEF = 8;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int unsigned STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_DECODING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd2;

endpackage

[hw/rtl/http_chunked_body_decoder.sv]
// HTTP chunked transfer decoder: strips chunk framing from a body byte stream.
//
//  channel | ports                                               | direction
//  --------+-----------------------------------------------------+----------
//  in      | in_valid, in_stall, in_data_byte                    | to block
//  out     | out_valid, out_stall, out_payload_byte,             | from block
//          | out_payload_valid, out_chunk_last, out_status       |
//
// One byte per clock sustained while out_stall is low; one result per byte.
// Each byte passes through the input register and then the result register before out_valid.
// Reset (rst_n low, synchronous) returns the decoder to the start of a size line.
// A stalled result holds in the output register; one more byte may wait in the
// input register, after which in_stall is raised.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int unsigned MAX_SIZE_DIGITS = MAX_SIZE_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_payload_byte,
  output logic                out_payload_valid,
  output logic                out_chunk_last,
  output logic [STATUS_W-1:0] out_status
);

  localparam int unsigned DW = $clog2(MAX_SIZE_DIGITS + 1);
  localparam logic [DW-1:0] DIG_MAX = DW'(MAX_SIZE_DIGITS);

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_CR,
    PH_LF,
    PH_DONE,
    PH_ERR
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [31:0]   chunk_length_r, chunk_length_nxt;
  logic [31:0]   bytes_done_r, bytes_done_nxt;
  logic [DW-1:0] digit_count_r, digit_count_nxt;
  logic          seen_cr_r, seen_cr_nxt;

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;

  logic          out_valid_r;
  logic [7:0]    out_payload_byte_r;
  logic          out_payload_valid_r;
  logic          out_chunk_last_r;
  logic [STATUS_W-1:0] out_status_r;

  logic          adv;
  logic          fire;
  logic          is_hex;
  logic [3:0]    hex_val;
  logic          res_valid;
  logic          res_last;
  logic [STATUS_W-1:0] res_status;

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  always_comb begin
    is_hex  = 1'b0;
    hex_val = s1_byte_r[3:0];
    if (s1_byte_r inside {[8'h30:8'h39]}) begin
      is_hex = 1'b1;
    end else if (s1_byte_r inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      is_hex  = 1'b1;
      hex_val = s1_byte_r[3:0] + 4'd9;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    chunk_length_nxt = chunk_length_r;
    bytes_done_nxt   = bytes_done_r;
    digit_count_nxt  = digit_count_r;
    seen_cr_nxt      = seen_cr_r;
    res_valid        = 1'b0;
    res_last         = 1'b0;
    res_status       = ST_DECODING;
    case (phase_r)
      PH_SIZE: begin
        if (seen_cr_r) begin
          if (s1_byte_r == CH_LF && digit_count_r != '0) begin
            bytes_done_nxt  = '0;
            digit_count_nxt = '0;
            seen_cr_nxt     = 1'b0;
            phase_nxt       = (chunk_length_r == 32'd0) ? PH_DONE : PH_DATA;
          end else begin
            phase_nxt = PH_ERR;
          end
        end else if (is_hex) begin
          if (digit_count_r >= DIG_MAX) begin
            phase_nxt = PH_ERR;
          end else begin
            chunk_length_nxt = {chunk_length_r[27:0], hex_val};
            digit_count_nxt  = digit_count_r + DW'(1);
          end
        end else if (s1_byte_r == CH_CR) begin
          seen_cr_nxt = 1'b1;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_DATA: begin
        res_valid      = 1'b1;
        bytes_done_nxt = bytes_done_r + 32'd1;
        if (bytes_done_nxt == chunk_length_r) begin
          res_last  = 1'b1;
          phase_nxt = PH_CR;
        end
      end
      PH_CR: begin
        phase_nxt = (s1_byte_r == CH_CR) ? PH_LF : PH_ERR;
      end
      PH_LF: begin
        if (s1_byte_r == CH_LF) begin
          phase_nxt        = PH_SIZE;
          chunk_length_nxt = '0;
          bytes_done_nxt   = '0;
          digit_count_nxt  = '0;
          seen_cr_nxt      = 1'b0;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_DONE: begin
        res_status = ST_FINISHED;
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase
    if (phase_nxt == PH_ERR) begin
      res_status = ST_ERROR;
      res_valid  = 1'b0;
      res_last   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SIZE;
      chunk_length_r <= '0;
      bytes_done_r   <= '0;
      digit_count_r  <= '0;
      seen_cr_r      <= 1'b0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      chunk_length_r <= chunk_length_nxt;
      bytes_done_r   <= bytes_done_nxt;
      digit_count_r  <= digit_count_nxt;
      seen_cr_r      <= seen_cr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      out_payload_byte_r  <= res_valid ? s1_byte_r : 8'h00;
      out_payload_valid_r <= res_valid;
      out_chunk_last_r    <= res_last;
      out_status_r        <= res_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_payload_byte_r;
  assign out_payload_valid = out_payload_valid_r;
  assign out_chunk_last    = out_chunk_last_r;
  assign out_status        = out_status_r;

endmodule

[hw/rtl/hcbd_checker.sv]
// Port-level assertions for the HTTP chunked body decoder, with bind.
module hcbd_checker
  import hcbd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [7:0]          out_payload_byte,
  input logic                out_payload_valid,
  input logic                out_chunk_last,
  input logic [STATUS_W-1:0] out_status
);

  logic err_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && !out_stall && out_status == ST_ERROR) begin
      err_seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_payload_valid) && $stable(out_chunk_last) && $stable(out_status))
    else $error("stalled result changed");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_status == ST_ERROR)
    else $error("left error state");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'h00 && !out_chunk_last)
    else $error("non-payload result carries data");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_status == ST_DECODING)
    else $error("payload with non-decoding status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_DECODING || out_status == ST_FINISHED
      || out_status == ST_ERROR)
    else $error("undefined status code");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_payload_byte  (out_payload_byte),
  .out_payload_valid (out_payload_valid),
  .out_chunk_last    (out_chunk_last),
  .out_status        (out_status)
);
